// File: src/complex_rank1_update_core_assert.svh
// assertion macros shared by the core
`ifndef COMPLEX_RANK1_UPDATE_CORE_ASSERT_SVH
`define COMPLEX_RANK1_UPDATE_CORE_ASSERT_SVH

// same cycle implication, masked during reset
`define CRU_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: check failed");

// next cycle implication, masked during reset
`define CRU_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: check failed");

// next cycle implication, also checked during reset
`define CRU_ASSERT_RST(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("%m: check failed");

`endif

// File: src/cru_pkg.sv
package cru_pkg;

  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 24;

  localparam int CNT_W       = 11;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_REAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IMAG = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_COLUMN = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } cru_op_t;

  // fac: word computes the column factor, otherwise an element update
  typedef struct packed {
    logic fac;
    logic cend;
    logic mend;
  } cru_tag_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic fac_pending;
  } cru_back_stat_t;

endpackage

// File: src/cru_queue.sv
module cru_queue import cru_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_word,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_word
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_word   = entry_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_word;
    end
  end

endmodule

// File: src/cru_front.sv
module cru_front import cru_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_value_real,
  input  logic signed [DATA_WIDTH-1:0] in_value_imag,
  input  logic [CNT_W-1:0]             row_count,
  input  logic [CNT_W-1:0]             col_count,
  output logic                         push_valid,
  input  logic                         push_ready,
  output cru_tag_t                     push_tag,
  output logic signed [DATA_WIDTH-1:0] push_a_re,
  output logic signed [DATA_WIDTH-1:0] push_a_im,
  output logic signed [DATA_WIDTH-1:0] push_x_re,
  output logic signed [DATA_WIDTH-1:0] push_x_im
);

  localparam int DW  = DATA_WIDTH;
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = (RIW + 1 > CNT_W) ? RIW + 1 : CNT_W;
  localparam int CCW = (CIW + 1 > CNT_W) ? CIW + 1 : CNT_W;

  logic [2*DW-1:0] x_mem_r [MAX_ROWS];
  logic [2*DW-1:0] rd_data_r;

  logic [RIW-1:0] wr_idx_r, wr_idx_nxt;
  logic [RIW-1:0] row_idx_r, row_idx_nxt;
  logic [CIW-1:0] col_idx_r, col_idx_nxt;
  logic           f_valid_r, f_valid_nxt;
  cru_tag_t       f_tag_r, f_tag_nxt;
  logic signed [DW-1:0] f_a_re_r, f_a_im_r;

  logic [RCW-1:0] rc_ext, m_eff;
  logic [CCW-1:0] cc_ext, n_eff;
  logic           wr_last, row_last, col_last;
  logic           accept, wr_en, rd_en, f_load;
  cru_op_t        op;

  assign rc_ext = RCW'(row_count);
  assign cc_ext = CCW'(col_count);

  always_comb begin
    if (rc_ext == '0) begin
      m_eff = RCW'(1);
    end else if (rc_ext > RCW'(MAX_ROWS)) begin
      m_eff = RCW'(MAX_ROWS);
    end else begin
      m_eff = rc_ext;
    end
    if (cc_ext == '0) begin
      n_eff = CCW'(1);
    end else if (cc_ext > CCW'(MAX_COLS)) begin
      n_eff = CCW'(MAX_COLS);
    end else begin
      n_eff = cc_ext;
    end
  end

  assign wr_last  = (RCW'(wr_idx_r) + RCW'(1)) >= m_eff;
  assign row_last = (RCW'(row_idx_r) + RCW'(1)) >= m_eff;
  assign col_last = (CCW'(col_idx_r) + CCW'(1)) >= n_eff;

  assign in_ready = !f_valid_r || push_ready;
  assign accept   = in_valid && in_ready;
  assign op       = cru_op_t'(in_opcode);

  always_comb begin
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    f_load      = 1'b0;
    wr_idx_nxt  = wr_idx_r;
    row_idx_nxt = row_idx_r;
    col_idx_nxt = col_idx_r;
    f_tag_nxt   = '0;
    if (accept) begin
      unique case (op)
        OP_LOAD_X: begin
          wr_en      = 1'b1;
          wr_idx_nxt = wr_last ? '0 : wr_idx_r + RIW'(1);
        end
        OP_COLUMN: begin
          f_load        = 1'b1;
          f_tag_nxt.fac = 1'b1;
          row_idx_nxt   = '0;
        end
        OP_UPDATE: begin
          f_load         = 1'b1;
          rd_en          = 1'b1;
          f_tag_nxt.cend = row_last;
          f_tag_nxt.mend = row_last && col_last;
          if (row_last) begin
            row_idx_nxt = '0;
            col_idx_nxt = col_last ? '0 : col_idx_r + CIW'(1);
          end else begin
            row_idx_nxt = row_idx_r + RIW'(1);
          end
        end
        OP_NONE: begin
        end
      endcase
    end
  end

  always_comb begin
    if (f_load) begin
      f_valid_nxt = 1'b1;
    end else if (push_ready) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      row_idx_r <= '0;
      col_idx_r <= '0;
      f_valid_r <= 1'b0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      row_idx_r <= row_idx_nxt;
      col_idx_r <= col_idx_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_tag_r  <= f_tag_nxt;
      f_a_re_r <= in_value_real;
      f_a_im_r <= in_value_imag;
    end
  end

  // x store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem_r[wr_idx_r] <= {in_value_imag, in_value_real};
    end
    if (rd_en) begin
      rd_data_r <= x_mem_r[row_idx_r];
    end
  end

  assign push_valid = f_valid_r;
  assign push_tag   = f_tag_r;
  assign push_a_re  = f_a_re_r;
  assign push_a_im  = f_a_im_r;
  assign push_x_re  = rd_data_r[DW-1:0];
  assign push_x_im  = rd_data_r[2*DW-1:DW];

endmodule

// File: src/cru_back.sv
module cru_back import cru_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] alpha_re,
  input  logic signed [DATA_WIDTH-1:0] alpha_im,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  cru_tag_t                     q_tag,
  input  logic signed [DATA_WIDTH-1:0] q_a_re,
  input  logic signed [DATA_WIDTH-1:0] q_a_im,
  input  logic signed [DATA_WIDTH-1:0] q_x_re,
  input  logic signed [DATA_WIDTH-1:0] q_x_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_real,
  output logic signed [DATA_WIDTH-1:0] out_imag,
  output logic                         out_cend,
  output logic                         out_mend,
  output logic                         out_ovf,
  output cru_back_stat_t               stat
);

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int SUMW = PW + 2;
  localparam int RW   = (SUMW - FRAC_BITS > 2) ? SUMW - FRAC_BITS : 2;
  localparam int TW   = ((RW > DW) ? RW : DW) + 1;
  localparam logic signed [SUMW-1:0] HALF = {{(SUMW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] fac_re_r, fac_im_r;

  // multiply stage
  logic                 s1_v_r, s1_v_nxt;
  cru_tag_t             s1_tag_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [DW-1:0] s1_a_re_r, s1_a_im_r;

  // round stage
  logic                 s2_v_r, s2_v_nxt;
  cru_tag_t             s2_tag_r;
  logic signed [RW-1:0] s2_rnd_re_r, s2_rnd_im_r;
  logic signed [DW-1:0] s2_a_re_r, s2_a_im_r;

  // output register
  logic                 out_v_r, out_v_nxt;
  logic signed [DW-1:0] out_re_r, out_im_r;
  logic                 out_cend_r, out_mend_r, out_ovf_r;

  logic signed [DW-1:0]   u0, v0, u1, v1, u2, v2, u3, v3, ad_re, ad_im;
  logic signed [PW-1:0]   p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic signed [SUMW-1:0] p0e, p1e, p2e, p3e, sum_re, sum_im, sh_re, sh_im;
  logic signed [TW-1:0]   tot_re, tot_im;
  logic signed [DW-1:0]   sat_re, sat_im;
  logic                   ovf_re, ovf_im;
  logic                   load, s1_adv, s2_adv, fac_pending;

  assign fac_pending = (s1_v_r && s1_tag_r.fac) || (s2_v_r && s2_tag_r.fac);
  assign s2_adv      = s2_v_r && (s2_tag_r.fac || !out_v_r || out_ready);
  assign s1_adv      = s1_v_r && (!s2_v_r || s2_adv);
  assign q_ready     = (!s1_v_r || s1_adv) && !(!q_tag.fac && fac_pending);
  assign load        = q_valid && q_ready;

  // column word: alpha*conj(y); update word: x*factor plus A
  always_comb begin
    if (q_tag.fac) begin
      u0 = alpha_re; v0 = q_a_re;
      u1 = alpha_im; v1 = q_a_im;
      u2 = alpha_im; v2 = q_a_re;
      u3 = alpha_re; v3 = q_a_im;
      ad_re = '0;
      ad_im = '0;
    end else begin
      u0 = q_x_re; v0 = fac_re_r;
      u1 = q_x_im; v1 = fac_im_r;
      u2 = q_x_re; v2 = fac_im_r;
      u3 = q_x_im; v3 = fac_re_r;
      ad_re = q_a_re;
      ad_im = q_a_im;
    end
  end

  assign p0_nxt = u0 * v0;
  assign p1_nxt = u1 * v1;
  assign p2_nxt = u2 * v2;
  assign p3_nxt = u3 * v3;

  assign p0e = SUMW'(p0_r);
  assign p1e = SUMW'(p1_r);
  assign p2e = SUMW'(p2_r);
  assign p3e = SUMW'(p3_r);

  always_comb begin
    if (s1_tag_r.fac) begin
      sum_re = p0e + p1e + HALF;
      sum_im = p2e - p3e + HALF;
    end else begin
      sum_re = p0e - p1e + HALF;
      sum_im = p2e + p3e + HALF;
    end
  end

  assign sh_re = sum_re >>> FRAC_BITS;
  assign sh_im = sum_im >>> FRAC_BITS;

  assign tot_re = TW'(s2_rnd_re_r) + TW'(s2_a_re_r);
  assign tot_im = TW'(s2_rnd_im_r) + TW'(s2_a_im_r);

  assign ovf_re = !((&tot_re[TW-1:DW-1]) || !(|tot_re[TW-1:DW-1]));
  assign ovf_im = !((&tot_im[TW-1:DW-1]) || !(|tot_im[TW-1:DW-1]));
  assign sat_re = ovf_re ? (tot_re[TW-1] ? DMIN : DMAX) : tot_re[DW-1:0];
  assign sat_im = ovf_im ? (tot_im[TW-1] ? DMIN : DMAX) : tot_im[DW-1:0];

  always_comb begin
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
    if (s2_adv && !s2_tag_r.fac) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      fac_re_r <= '0;
      fac_im_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_adv && s2_tag_r.fac) begin
        fac_re_r <= sat_re;
        fac_im_r <= sat_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_tag_r  <= q_tag;
      p0_r      <= p0_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      s1_a_re_r <= ad_re;
      s1_a_im_r <= ad_im;
    end
    if (s1_adv) begin
      s2_tag_r    <= s1_tag_r;
      s2_rnd_re_r <= sh_re[RW-1:0];
      s2_rnd_im_r <= sh_im[RW-1:0];
      s2_a_re_r   <= s1_a_re_r;
      s2_a_im_r   <= s1_a_im_r;
    end
    if (s2_adv && !s2_tag_r.fac) begin
      out_re_r   <= sat_re;
      out_im_r   <= sat_im;
      out_cend_r <= s2_tag_r.cend;
      out_mend_r <= s2_tag_r.mend;
      out_ovf_r  <= ovf_re || ovf_im;
    end
  end

  assign out_valid = out_v_r;
  assign out_real  = out_re_r;
  assign out_imag  = out_im_r;
  assign out_cend  = out_cend_r;
  assign out_mend  = out_mend_r;
  assign out_ovf   = out_ovf_r;

  assign stat.s1_valid    = s1_v_r;
  assign stat.s2_valid    = s2_v_r;
  assign stat.fac_pending = fac_pending;

endmodule

// File: src/complex_rank1_update_core.sv
// channel | dir | handshake                  | word
// in      | in  | in_valid / in_ready        | opcode, value_real, value_imag
// out     | out | out_valid / out_ready      | updated_real/imag, column_end, matrix_end, overflow
// cfg     | in  | cfg_we, no back pressure   | cfg_index, cfg_data
//
// one word per cycle while the output is not stalled and no update waits for the factor; an update word leaves through
// the front register, queue, multiply stage, round stage and output register
// an update word right behind a column word waits in the queue until the factor is stored
// synchronous reset clears control and factor; the x store holds nothing until loaded
// a stalled output fills the back pipeline, then the queue, then drops in_ready
module complex_rank1_update_core import cru_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_value_real,
  input  logic signed [DATA_WIDTH-1:0] in_value_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_updated_real,
  output logic signed [DATA_WIDTH-1:0] out_updated_imag,
  output logic                         out_column_end,
  output logic                         out_matrix_end,
  output logic                         out_overflow,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int TAG_W = $bits(cru_tag_t);
  localparam int QW = TAG_W + 4 * DW;

  logic [CNT_W-1:0]     row_count_r, col_count_r;
  logic signed [DW-1:0] alpha_re_r, alpha_im_r;

  logic                 push_valid, push_ready;
  cru_tag_t             push_tag;
  logic signed [DW-1:0] push_a_re, push_a_im, push_x_re, push_x_im;
  logic [QW-1:0]        push_word, q_word;

  logic                 q_pop_valid, q_pop_ready;
  cru_tag_t             q_tag;
  logic signed [DW-1:0] q_a_re, q_a_im, q_x_re, q_x_im;
  cru_back_stat_t       bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(1);
      col_count_r <= CNT_W'(1);
      alpha_re_r  <= '0;
      alpha_im_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:  row_count_r <= cfg_data[CNT_W-1:0];
        REG_COL_COUNT:  col_count_r <= cfg_data[CNT_W-1:0];
        REG_ALPHA_REAL: alpha_re_r  <= cfg_data[DW-1:0];
        REG_ALPHA_IMAG: alpha_im_r  <= cfg_data[DW-1:0];
      endcase
    end
  end

  cru_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value_real (in_value_real),
    .in_value_imag (in_value_imag),
    .row_count     (row_count_r),
    .col_count     (col_count_r),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_tag      (push_tag),
    .push_a_re     (push_a_re),
    .push_a_im     (push_a_im),
    .push_x_re     (push_x_re),
    .push_x_im     (push_x_im)
  );

  assign push_word = {push_tag, push_a_re, push_a_im, push_x_re, push_x_im};

  cru_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_word   (q_word)
  );

  assign {q_tag, q_a_re, q_a_im, q_x_re, q_x_im} = q_word;

  cru_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha_re  (alpha_re_r),
    .alpha_im  (alpha_im_r),
    .q_valid   (q_pop_valid),
    .q_ready   (q_pop_ready),
    .q_tag     (q_tag),
    .q_a_re    (q_a_re),
    .q_a_im    (q_a_im),
    .q_x_re    (q_x_re),
    .q_x_im    (q_x_im),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_real  (out_updated_real),
    .out_imag  (out_updated_imag),
    .out_cend  (out_column_end),
    .out_mend  (out_matrix_end),
    .out_ovf   (out_overflow),
    .stat      (bk_stat)
  );

`include "complex_rank1_update_core_assert.svh"

  `CRU_ASSERT_IMP(a_mend_has_cend, out_valid && out_matrix_end, out_column_end)
  `CRU_ASSERT_IMP(a_no_stale_factor, q_pop_valid && q_pop_ready && !q_tag.fac, !bk_stat.fac_pending)
  `CRU_ASSERT_NXT(a_front_holds, push_valid && !push_ready, push_valid)
  `CRU_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && !bk_stat.s1_valid && !bk_stat.s2_valid)

endmodule

// File: dv/testbench.sv
module testbench;
  import cru_pkg::*;

  localparam int DW    = DEF_DATA_WIDTH;
  localparam int FB    = DEF_FRAC_BITS;
  localparam int LIMIT = 200000;
  localparam int TAIL  = 12;
  localparam int GOAL  = 680;

  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = 1 <<< FB;

  typedef logic signed [71:0] wide_t;

  typedef struct {
    cru_op_t                op;
    logic signed [DW-1:0]   re;
    logic signed [DW-1:0]   im;
  } word_t;

  typedef struct {
    logic signed [DW-1:0]   re;
    logic signed [DW-1:0]   im;
    logic                   cend;
    logic                   mend;
    logic                   ovf;
  } elem_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_opcode = '0;
  logic signed [DW-1:0]   in_value_real = '0;
  logic signed [DW-1:0]   in_value_imag = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [DW-1:0]   out_updated_real;
  logic signed [DW-1:0]   out_updated_imag;
  logic                   out_column_end;
  logic                   out_matrix_end;
  logic                   out_overflow;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  complex_rank1_update_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value_real    (in_value_real),
    .in_value_imag    (in_value_imag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_updated_real (out_updated_real),
    .out_updated_imag (out_updated_imag),
    .out_column_end   (out_column_end),
    .out_matrix_end   (out_matrix_end),
    .out_overflow     (out_overflow),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow of the core
  logic signed [DW-1:0]   xs_re [DEF_MAX_ROWS];
  logic signed [DW-1:0]   xs_im [DEF_MAX_ROWS];
  int                     wr_idx = 0;
  int                     row_idx = 0;
  int                     col_idx = 0;
  logic signed [DW-1:0]   fac_re = '0;
  logic signed [DW-1:0]   fac_im = '0;
  logic [CNT_W-1:0]       cfg_rows = 1;
  logic [CNT_W-1:0]       cfg_cols = 1;
  logic signed [DW-1:0]   alpha_re = '0;
  logic signed [DW-1:0]   alpha_im = '0;

  word_t                  word_backlog[$];
  elem_t                  updates_due[$];
  word_t                  cur_word;
  bit                     calm = 1'b0;
  int                     errors = 0;
  int                     checked = 0;
  int                     n_words = 0;
  int                     n_settings = 0;
  int                     cycles = 0;

  function automatic wide_t mul(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // round to nearest, ties up, of (a + b) / 2^FB
  function automatic wide_t round_q(wide_t a, wide_t b);
    wide_t half;
    half = 1;
    half = half <<< (FB - 1);
    return (a + b + half) >>> FB;
  endfunction

  // msb is the saturation flag
  function automatic logic [DW:0] clip(wide_t v);
    if (v > wide_t'(WMAX)) return {1'b1, WMAX};
    if (v < wide_t'(WMIN)) return {1'b1, WMIN};
    return {1'b0, v[DW-1:0]};
  endfunction

  function automatic int clamp_cnt(logic [CNT_W-1:0] v, int hi);
    if (v == 0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  task automatic apply_word(word_t w);
    int          m;
    int          n;
    int          k;
    logic [DW:0] r;
    logic [DW:0] i;
    elem_t       e;
    m = clamp_cnt(cfg_rows, DEF_MAX_ROWS);
    n = clamp_cnt(cfg_cols, DEF_MAX_COLS);
    case (w.op)
      OP_LOAD_X: begin
        k = (wr_idx < DEF_MAX_ROWS) ? wr_idx : 0;
        xs_re[k] = w.re;
        xs_im[k] = w.im;
        wr_idx = (k + 1 >= m) ? 0 : k + 1;
      end
      OP_COLUMN: begin
        r = clip(round_q(mul(alpha_re, w.re), mul(alpha_im, w.im)));
        i = clip(round_q(mul(alpha_im, w.re), -mul(alpha_re, w.im)));
        fac_re = r[DW-1:0];
        fac_im = i[DW-1:0];
        row_idx = 0;
      end
      OP_UPDATE: begin
        k = (row_idx < DEF_MAX_ROWS) ? row_idx : 0;
        r = clip(wide_t'(w.re) + round_q(mul(xs_re[k], fac_re), -mul(xs_im[k], fac_im)));
        i = clip(wide_t'(w.im) + round_q(mul(xs_re[k], fac_im), mul(xs_im[k], fac_re)));
        e.re = r[DW-1:0];
        e.im = i[DW-1:0];
        e.ovf = r[DW] | i[DW];
        e.cend = (k + 1 >= m);
        e.mend = 1'b0;
        if (e.cend) begin
          row_idx = 0;
          if (col_idx + 1 >= n) begin
            e.mend = 1'b1;
            col_idx = 0;
          end else begin
            col_idx = col_idx + 1;
          end
        end else begin
          row_idx = k + 1;
        end
        updates_due.push_back(e);
      end
      default: ;
    endcase
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_word(cur_word);
      if (!in_valid || in_ready) begin
        if (word_backlog.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          cur_word = word_backlog.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_word.op;
          in_value_real <= cur_word.re;
          in_value_imag <= cur_word.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    elem_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (updates_due.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = updates_due.pop_front();
          checked++;
          if (out_updated_real !== e.re) begin
            $error("updated_real expected %0d actual %0d", e.re, out_updated_real);
            errors++;
          end
          if (out_updated_imag !== e.im) begin
            $error("updated_imag expected %0d actual %0d", e.im, out_updated_imag);
            errors++;
          end
          if (out_column_end !== e.cend) begin
            $error("column_end expected %0d actual %0d", e.cend, out_column_end);
            errors++;
          end
          if (out_matrix_end !== e.mend) begin
            $error("matrix_end expected %0d actual %0d", e.mend, out_matrix_end);
            errors++;
          end
          if (out_overflow !== e.ovf) begin
            $error("overflow expected %0d actual %0d", e.ovf, out_overflow);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  task automatic push_word(cru_op_t op, logic signed [DW-1:0] re, logic signed [DW-1:0] im);
    word_t w;
    w.op = op;
    w.re = re;
    w.im = im;
    word_backlog.push_back(w);
    if (op != OP_NONE) n_words++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (word_backlog.size() != 0 || in_valid || updates_due.size() != 0) @(negedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic set_regs(logic [CNT_W-1:0] rc, logic [CNT_W-1:0] cc,
                          logic signed [DW-1:0] ar, logic signed [DW-1:0] ai);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data <= {21'($urandom), rc};
    cfg_rows = rc;
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_data <= {21'($urandom), cc};
    cfg_cols = cc;
    @(posedge clk);
    cfg_index <= REG_ALPHA_REAL;
    cfg_data <= ar;
    alpha_re = ar;
    @(posedge clk);
    cfg_index <= REG_ALPHA_IMAG;
    cfg_data <= ai;
    alpha_im = ai;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [DW-1:0] pick_val();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return DW'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
      7: begin
        case ($urandom_range(3))
          0:       return WMAX;
          1:       return WMIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      8:       return '0;
      default: return $urandom_range(1) ? ONE : -ONE;
    endcase
  endfunction

  task automatic run_random_phase();
    logic [CNT_W-1:0]     rc;
    logic [CNT_W-1:0]     cc;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    int                   m;
    int                   cols;
    int                   rows;
    int                   passes;
    case ($urandom_range(19))
      0:       rc = 0;
      1:       rc = $urandom_range(9, 40);
      default: rc = $urandom_range(1, 8);
    endcase
    case ($urandom_range(19))
      0:       cc = 0;
      1:       cc = $urandom_range(1025, 2047);
      default: cc = $urandom_range(1, 4);
    endcase
    case ($urandom_range(7))
      0: begin
        ar = '0;
        ai = '0;
      end
      1: begin
        ar = $urandom_range(1) ? WMAX : WMIN;
        ai = $urandom_range(1) ? WMAX : WMIN;
      end
      default: begin
        ar = pick_val();
        ai = pick_val();
      end
    endcase
    set_regs(rc, cc, ar, ai);
    m = clamp_cnt(rc, DEF_MAX_ROWS);
    cols = clamp_cnt(cc, DEF_MAX_COLS);
    if (cols > 5) cols = 5;
    // every row of x gets written before any update reads it
    repeat (m + 1) push_word(OP_LOAD_X, pick_val(), pick_val());
    passes = $urandom_range(1, 2);
    repeat (passes) begin
      for (int c = 0; c < cols; c++) begin
        if ($urandom_range(9) == 0) push_word(cru_op_t'($urandom_range(3)), pick_val(), pick_val());
        if ($urandom_range(9) == 0) push_word(OP_COLUMN, '0, '0);
        else push_word(OP_COLUMN, pick_val(), pick_val());
        rows = ($urandom_range(9) == 0) ? $urandom_range(0, m) : m;
        repeat (rows) push_word(OP_UPDATE, pick_val(), pick_val());
      end
    end
    drain();
  endtask

  initial begin : stimulus
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one row, one column, alpha zero
    push_word(OP_LOAD_X, WMAX, WMIN);
    push_word(OP_NONE, pick_val(), pick_val());
    push_word(OP_COLUMN, ONE, WMIN);
    push_word(OP_UPDATE, WMAX, WMIN);
    push_word(OP_UPDATE, '0, '1);
    drain();

    // saturated factor, saturated elements, zero y
    set_regs(2, 2, WMAX, WMAX);
    push_word(OP_LOAD_X, WMIN, WMIN);
    push_word(OP_LOAD_X, WMAX, '0);
    push_word(OP_COLUMN, WMIN, WMIN);
    push_word(OP_UPDATE, WMAX, WMAX);
    push_word(OP_UPDATE, WMIN, WMIN);
    push_word(OP_COLUMN, '0, '0);
    push_word(OP_UPDATE, WMAX, WMIN);
    push_word(OP_UPDATE, 1, -1);
    drain();

    // counts out of range, rounding tie
    set_regs(0, 2047, ONE, '0);
    push_word(OP_LOAD_X, 1, -1);
    push_word(OP_COLUMN, ONE >>> 1, '0);
    push_word(OP_UPDATE, '0, '0);
    push_word(OP_COLUMN, WMIN, WMAX);
    push_word(OP_UPDATE, pick_val(), pick_val());
    drain();

    n_words = 0;
    phase = 0;
    while (n_words < GOAL) begin
      calm = (phase == 4 || phase == 5);
      run_random_phase();
      phase++;
    end
    calm = 1'b0;
    drain();

    $display("run covered %0d register settings and %0d random words after the directed part",
             n_settings, n_words);
    $display("%0d updated elements compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
